>>> sv/wal_record_checker_unit_macros.svh
// Assertion macros shared by the wal record checker RTL.
// Each macro expects clk and rst_n in the enclosing module scope.
`ifndef WAL_RECORD_CHECKER_UNIT_MACROS_SVH
`define WAL_RECORD_CHECKER_UNIT_MACROS_SVH

// Expression must hold at every clock edge outside reset
`define WRC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define WRC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/wrc_pkg.sv
// Package for the wal record checker: item types, codes, constants, CRC step.
// No dependencies.
`timescale 1ns / 1ps

package wrc_pkg;

    // Magic words and CRC constants
    localparam logic [31:0] FILE_MAGIC  = 32'h5241_4654;
    localparam logic [31:0] REC_MAGIC   = 32'hE0E0_E0E0;
    localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

    // Byte positions in the file header
    localparam logic [31:0] MAGIC_LAST  = 32'd3;
    localparam logic [31:0] TERM_LAST   = 32'd15;
    localparam logic [31:0] VOTE_FIRST  = 32'd16;
    localparam logic [31:0] VOTE_LAST   = 32'd52;
    localparam logic [31:0] HEADER_LAST = 32'd63;

    // Byte positions in a record header
    localparam logic [31:0] REC_TERM_LAST  = 32'd11;
    localparam logic [31:0] REC_INDEX_LAST = 32'd19;
    localparam logic [31:0] REC_KIND_AT    = 32'd20;
    localparam logic [31:0] RECHDR_LAST    = 32'd24;
    localparam logic [31:0] CHECK_LAST     = 32'd3;

    // Parser phases
    typedef enum logic [2:0] {
        PH_FILE,
        PH_RECHDR,
        PH_PAYLOAD,
        PH_CRC,
        PH_STOPPED
    } phase_t;

    // Result kinds
    localparam logic [2:0] KIND_TERM     = 3'd0;
    localparam logic [2:0] KIND_VOTE     = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
    localparam logic [2:0] KIND_VERIFIED = 3'd3;
    localparam logic [2:0] KIND_STOPPED  = 3'd4;

    // Stop status codes
    localparam logic [2:0] ST_CLEAN_END     = 3'd0;
    localparam logic [2:0] ST_BAD_FILE      = 3'd1;
    localparam logic [2:0] ST_SHORT_HEADER  = 3'd2;
    localparam logic [2:0] ST_SHORT_RECHDR  = 3'd3;
    localparam logic [2:0] ST_BAD_ENTRY     = 3'd4;
    localparam logic [2:0] ST_SHORT_PAYLOAD = 3'd5;
    localparam logic [2:0] ST_SHORT_CHECK   = 3'd6;
    localparam logic [2:0] ST_CHECK_FAIL    = 3'd7;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [2:0]  stop_status;
        logic [63:0] term_value;
        logic [63:0] entry_index;
        logic [7:0]  entry_kind;
        logic [31:0] payload_length;
        logic [7:0]  out_byte;
    } out_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // One byte of reflected CRC-32
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/wrc_stream_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on wrc_pkg.
`timescale 1ns / 1ps

interface wrc_byte_if;
    logic               valid;
    logic               ready;
    wrc_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wrc_result_if;
    logic               valid;
    logic               ready;
    wrc_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/wrc_front.sv
// Front end: parses the log byte stream, runs the record CRC, classifies results.
// Depends on wrc_pkg, wrc_stream_if and the assertion macro header.
`timescale 1ns / 1ps
`include "wal_record_checker_unit_macros.svh"

module wrc_front (
    input  logic                clk,
    input  logic                rst_n,
    wrc_byte_if.sink            log_bytes,
    input  wrc_pkg::queue_stat_t qstat,
    output logic                push_valid,
    output wrc_pkg::out_item_t  push_item
);

    wrc_pkg::phase_t phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [63:0] shift_reg, shift_next;
    logic [63:0] term_reg, term_next;
    logic [63:0] index_reg, index_next;
    logic [7:0]  kind_reg, kind_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] crc_reg, crc_next;

    logic        accept;
    logic [7:0]  b;
    logic [63:0] shifted;
    logic [31:0] count_inc;
    logic [31:0] crc_step;
    logic        eof_beat;
    logic        stopped;
    logic        at_start;

    // Take a beat whenever the queue has room for its result
    assign log_bytes.ready = !qstat.full;
    assign accept          = log_bytes.valid && log_bytes.ready;
    assign b               = log_bytes.payload.file_byte;
    assign shifted         = {shift_reg[55:0], b};
    assign count_inc       = count_reg + 32'd1;
    assign crc_step        = wrc_pkg::crc_update(crc_reg, b);

    // Status terms for the checks below
    assign eof_beat = accept && log_bytes.payload.end_of_file;
    assign stopped  = (phase_reg == wrc_pkg::PH_STOPPED);
    assign at_start = (phase_reg == wrc_pkg::PH_FILE) && (count_reg == '0);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wrc_pkg::PH_FILE;
            count_reg  <= '0;
            shift_reg  <= '0;
            term_reg   <= '0;
            index_reg  <= '0;
            kind_reg   <= '0;
            length_reg <= '0;
            crc_reg    <= wrc_pkg::CRC_ONES;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            term_reg   <= term_next;
            index_reg  <= index_next;
            kind_reg   <= kind_next;
            length_reg <= length_next;
            crc_reg    <= crc_next;
        end
    end

    // Parser next state and result classification
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        shift_next  = shift_reg;
        term_next   = term_reg;
        index_next  = index_reg;
        kind_next   = kind_reg;
        length_next = length_reg;
        crc_next    = crc_reg;
        push_valid  = 1'b0;
        push_item   = '0;

        if (accept)
        begin
            if (log_bytes.payload.end_of_file)
            begin
                // End of file: report clean end or truncation, then reset state
                push_valid = (phase_reg != wrc_pkg::PH_STOPPED);
                push_item.result_kind = wrc_pkg::KIND_STOPPED;
                case (phase_reg)
                    wrc_pkg::PH_FILE:    push_item.stop_status = wrc_pkg::ST_SHORT_HEADER;
                    wrc_pkg::PH_RECHDR:  push_item.stop_status = (count_reg == '0) ?
                                             wrc_pkg::ST_CLEAN_END : wrc_pkg::ST_SHORT_RECHDR;
                    wrc_pkg::PH_PAYLOAD: push_item.stop_status = wrc_pkg::ST_SHORT_PAYLOAD;
                    default:             push_item.stop_status = wrc_pkg::ST_SHORT_CHECK;
                endcase
                phase_next  = wrc_pkg::PH_FILE;
                count_next  = '0;
                shift_next  = '0;
                term_next   = '0;
                index_next  = '0;
                kind_next   = '0;
                length_next = '0;
                crc_next    = wrc_pkg::CRC_ONES;
            end
            else
            begin
                case (phase_reg)
                    wrc_pkg::PH_FILE:
                    begin
                        shift_next = shifted;
                        count_next = count_inc;
                        if (count_reg == wrc_pkg::MAGIC_LAST &&
                            shifted[31:0] != wrc_pkg::FILE_MAGIC)
                        begin
                            phase_next            = wrc_pkg::PH_STOPPED;
                            push_valid            = 1'b1;
                            push_item.result_kind = wrc_pkg::KIND_STOPPED;
                            push_item.stop_status = wrc_pkg::ST_BAD_FILE;
                        end
                        else
                        begin
                            if (count_reg == wrc_pkg::TERM_LAST)
                            begin
                                push_valid            = 1'b1;
                                push_item.result_kind = wrc_pkg::KIND_TERM;
                                push_item.term_value  = shifted;
                            end
                            else if (count_reg >= wrc_pkg::VOTE_FIRST &&
                                     count_reg <= wrc_pkg::VOTE_LAST)
                            begin
                                push_valid            = 1'b1;
                                push_item.result_kind = wrc_pkg::KIND_VOTE;
                                push_item.out_byte    = b;
                            end
                            if (count_reg == wrc_pkg::HEADER_LAST)
                            begin
                                phase_next = wrc_pkg::PH_RECHDR;
                                count_next = '0;
                                crc_next   = wrc_pkg::CRC_ONES;
                            end
                        end
                    end
                    wrc_pkg::PH_RECHDR:
                    begin
                        crc_next   = crc_step;
                        shift_next = shifted;
                        count_next = count_inc;
                        if (count_reg == wrc_pkg::MAGIC_LAST &&
                            shifted[31:0] != wrc_pkg::REC_MAGIC)
                        begin
                            phase_next            = wrc_pkg::PH_STOPPED;
                            push_valid            = 1'b1;
                            push_item.result_kind = wrc_pkg::KIND_STOPPED;
                            push_item.stop_status = wrc_pkg::ST_BAD_ENTRY;
                        end
                        else if (count_reg == wrc_pkg::REC_TERM_LAST)
                        begin
                            term_next = shifted;
                        end
                        else if (count_reg == wrc_pkg::REC_INDEX_LAST)
                        begin
                            index_next = shifted;
                        end
                        else if (count_reg == wrc_pkg::REC_KIND_AT)
                        begin
                            kind_next = b;
                        end
                        else if (count_reg == wrc_pkg::RECHDR_LAST)
                        begin
                            length_next = shifted[31:0];
                            count_next  = '0;
                            phase_next  = (shifted[31:0] != '0) ?
                                          wrc_pkg::PH_PAYLOAD : wrc_pkg::PH_CRC;
                        end
                    end
                    wrc_pkg::PH_PAYLOAD:
                    begin
                        crc_next              = crc_step;
                        count_next            = count_inc;
                        push_valid            = 1'b1;
                        push_item.result_kind = wrc_pkg::KIND_PAYLOAD;
                        push_item.out_byte    = b;
                        if (count_inc == length_reg)
                        begin
                            count_next = '0;
                            phase_next = wrc_pkg::PH_CRC;
                        end
                    end
                    wrc_pkg::PH_CRC:
                    begin
                        shift_next = shifted;
                        count_next = count_inc;
                        if (count_reg == wrc_pkg::CHECK_LAST)
                        begin
                            push_valid = 1'b1;
                            if (shifted[31:0] != ~crc_reg)
                            begin
                                phase_next            = wrc_pkg::PH_STOPPED;
                                push_item.result_kind = wrc_pkg::KIND_STOPPED;
                                push_item.stop_status = wrc_pkg::ST_CHECK_FAIL;
                            end
                            else
                            begin
                                push_item.result_kind    = wrc_pkg::KIND_VERIFIED;
                                push_item.term_value     = term_reg;
                                push_item.entry_index    = index_reg;
                                push_item.entry_kind     = kind_reg;
                                push_item.payload_length = length_reg;
                                phase_next               = wrc_pkg::PH_RECHDR;
                                count_next               = '0;
                                crc_next                 = wrc_pkg::CRC_ONES;
                            end
                        end
                    end
                    default:
                    begin
                        // stopped: discard bytes until end of file
                    end
                endcase
            end
        end
    end

    `WRC_ASSERT_IMPLIES(a_stopped_silent, accept && stopped, !push_valid, "push while stopped")
    `WRC_ASSERT_NEXT(a_eof_resets, eof_beat, at_start, "end of file did not reset parser")

endmodule

>>> sv/wrc_queue.sv
// Short result queue between parser front end and output stage.
// Depends on wrc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "wal_record_checker_unit_macros.svh"

module wrc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wrc_pkg::out_item_t   push_item,
    input  logic                 pop,
    output wrc_pkg::out_item_t   head_item,
    output wrc_pkg::queue_stat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wrc_pkg::out_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign qstat.full  = (cnt_reg == CNT_FULL);
    assign qstat.empty = (cnt_reg == '0);
    assign head_item   = mem[rd_ptr_reg];

    // Pointer and fill-count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `WRC_ASSERT_ALWAYS(a_no_overflow, !(push && qstat.full && !pop), "push into full queue")
    `WRC_ASSERT_ALWAYS(a_no_underflow, !(pop && qstat.empty), "pop from empty queue")
    `WRC_ASSERT_NEXT(a_fill_tracks, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "fill count lost a push")

endmodule

>>> sv/wrc_back.sv
// Back end: output register that drains the result queue onto the result channel.
// Depends on wrc_pkg and wrc_stream_if.
`timescale 1ns / 1ps

module wrc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wrc_pkg::out_item_t   head_item,
    input  wrc_pkg::queue_stat_t qstat,
    output logic                 pop,
    wrc_result_if.source         results
);

    logic               out_valid_reg, out_valid_next;
    wrc_pkg::out_item_t out_item_reg;

    // Refill the output register when it is empty or its beat is being taken
    assign pop            = !qstat.empty && (!out_valid_reg || results.ready);
    assign out_valid_next = pop ? 1'b1 : (out_valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= head_item;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_item_reg;

endmodule

>>> sv/wal_record_checker_unit.sv
// Top level of the wal record checker: front end parser, result queue, output stage.
// Depends on wrc_pkg, wrc_stream_if, wrc_front, wrc_queue and wrc_back.
//
// Usage:
//   log_bytes carries the log file one byte per beat (file_byte) or an
//   end-of-file marker (end_of_file = 1, byte ignored). results carries at
//   most one result per input beat: the file term, each voted-for byte,
//   each payload byte, a verified record summary, or a stop with status.
//   Throughput is one byte per cycle while the queue is not full; the parser
//   state and the per-byte CRC-32 update complete in the cycle the beat is
//   accepted. A result is written into the queue at the edge that accepts
//   its input beat and, with the output stage free, is on the results
//   channel from the next edge on.
//   Receiver stall: results queue in a QUEUE_DEPTH-entry buffer plus the
//   output register; log_bytes.ready drops only when the queue is full.
//   Reset: parser waits for a file header, queue and output are empty.
//   After a stop, bytes are dropped until the end-of-file beat, which
//   returns the parser to its reset state.
`timescale 1ns / 1ps

module wal_record_checker_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    wrc_byte_if.sink      log_bytes,
    wrc_result_if.source  results
);

    logic                 push_valid;
    wrc_pkg::out_item_t   push_item;
    logic                 pop;
    wrc_pkg::out_item_t   head_item;
    wrc_pkg::queue_stat_t qstat;

    wrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .log_bytes  (log_bytes),
        .qstat      (qstat),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    wrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    wrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .qstat     (qstat),
        .pop       (pop),
        .results   (results)
    );

endmodule
